[hdl/cwg_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the crank trigger wheel generator.
// No dependencies; imported by every module of the block.
package cwg_pkg;

    localparam int US_PER_MINUTE = 60000000;

    localparam int RPM_W      = 16;
    localparam int CNT_W      = 8;   // mode, tooth count, missing count
    localparam int IDX_W      = 8;
    localparam int QUO_W      = 26;  // tooth period
    localparam int HALF_W     = QUO_W - 1;
    localparam int DIV_W      = RPM_W + CNT_W;
    localparam int DIV_STEP_W = $clog2(QUO_W);

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 16;

    localparam logic [QUO_W-1:0] DIVIDEND = QUO_W'(US_PER_MINUTE);

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_RPM     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_MODE   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_TOOTH_COUNT   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_MISSING_COUNT = CFG_IDX_W'(3);

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_HIGH  = 2'd1,
        KIND_LOW   = 2'd2,
        KIND_GAP   = 2'd3
    } kind_t;

    typedef struct packed {
        logic mul_load;     // latch rpm * teeth
        logic div_start;
        logic period_load;  // latch quotient as tooth period
        logic enter_first;  // enter first phase of the revolution
        logic step;         // emit word, advance if tick
        logic advance;      // the current word carries a tick
    } cwg_cmd_t;

    typedef struct packed {
        logic at_start;
        logic run_ok;
    } cwg_status_t;

endpackage

[hdl/crank_trigger_wheel_generator.sv]
`timescale 1ns / 1ps
// Crank trigger wheel generator: one output word per input word; each tick is one us.
// A tick that starts a revolution (with rpm and teeth nonzero) runs the product, the
// bit-serial period divider (26 quotient bits, one per cycle), latch and entry steps
// before its word is emitted; every other word is accepted, then emitted. The output
// register lets the next word be accepted while a finished word waits. Tooth period is
// 60e6 / (rpm * teeth), latched once per revolution; mode and counts are read live.
// Depends on cwg_pkg, cwg_ctl, cwg_dp and cwg_div.
module crank_trigger_wheel_generator import cwg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [0] tick, rest zero
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata    // [0] pin_level, [8:1] tooth_position,
                                                  // [9] in_gap, rest zero
);

    cwg_cmd_t         cmd;
    cwg_status_t      status;
    logic [DIV_W-1:0] divisor;
    logic [QUO_W-1:0] quotient;
    logic             div_done;
    logic             pin_level;
    logic [IDX_W-1:0] tooth_position;
    logic             in_gap;

    assign cfg_ready = 1'b1;

    cwg_ctl u_ctl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .tick          (s_axis_tdata[0]),
        .status        (status),
        .div_done      (div_done),
        .cmd           (cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    cwg_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .divisor  (divisor),
        .quotient (quotient),
        .done     (div_done)
    );

    cwg_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .status         (status),
        .divisor        (divisor),
        .quotient       (quotient),
        .pin_level      (pin_level),
        .tooth_position (tooth_position),
        .in_gap         (in_gap)
    );

    assign m_axis_tdata = {(M_TDATA_W-IDX_W-2)'(0), in_gap, tooth_position, pin_level};

endmodule

[hdl/cwg_div.sv]
`timescale 1ns / 1ps
// Restoring divider: one quotient bit per cycle of US_PER_MINUTE / divisor.
// Depends on cwg_pkg.
module cwg_div import cwg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] divisor,
    output logic [QUO_W-1:0] quotient,
    output logic             done
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [QUO_W-1:0]      quo_reg, quo_next;

    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    logic           fits;

    always_comb
    begin
        trial = {rem_reg, DIVIDEND[step_reg]};
        diff  = trial - {1'b0, divisor};
        fits  = (trial >= {1'b0, divisor});

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;

        if (start)
        begin
            busy_next = 1'b1;
            step_next = DIV_STEP_W'(QUO_W - 1);
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], fits};
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a finished run");

endmodule

[hdl/cwg_dp.sv]
`timescale 1ns / 1ps
// Datapath: config registers, period product, wheel phase state and output word.
// Depends on cwg_pkg; driven by cwg_ctl commands, fed by cwg_div.
module cwg_dp import cwg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  cwg_cmd_t              cmd,
    output cwg_status_t           status,
    output logic [DIV_W-1:0]      divisor,
    input  logic [QUO_W-1:0]      quotient,
    output logic                  pin_level,
    output logic [IDX_W-1:0]      tooth_position,
    output logic                  in_gap
);

    logic [RPM_W-1:0] speed_rpm_reg;
    logic [CNT_W-1:0] signal_mode_reg;
    logic [CNT_W-1:0] tooth_count_reg;
    logic [CNT_W-1:0] missing_count_reg;

    logic [DIV_W-1:0]  product_reg;
    logic [QUO_W-1:0]  period_reg, period_next;
    logic [HALF_W-1:0] half_reg, half_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [QUO_W-1:0]  cnt_reg, cnt_next;
    kind_t             kind_reg, kind_next;

    logic              pin_reg;
    logic [IDX_W-1:0]  pos_reg;
    logic              gap_reg;

    // phase entry search
    logic [IDX_W:0]    ent_from;
    logic [IDX_W:0]    ent_cand;
    logic [IDX_W:0]    n_pos;
    logic [IDX_W-1:0]  gap_first;
    logic              gap_en;
    kind_t             ent_kind;
    logic [IDX_W-1:0]  ent_idx;

    logic [QUO_W-1:0]  cnt_inc;
    logic [QUO_W-1:0]  phase_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_rpm_reg     <= '0;
            signal_mode_reg   <= '0;
            tooth_count_reg   <= CNT_W'(60);
            missing_count_reg <= CNT_W'(2);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SPEED_RPM:     speed_rpm_reg     <= cfg_data[RPM_W-1:0];
                REG_SIGNAL_MODE:   signal_mode_reg   <= cfg_data[CNT_W-1:0];
                REG_TOOTH_COUNT:   tooth_count_reg   <= cfg_data[CNT_W-1:0];
                REG_MISSING_COUNT: missing_count_reg <= cfg_data[CNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // (60e6 / rpm) / teeth == 60e6 / (rpm * teeth)
    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
            product_reg <= DIV_W'(speed_rpm_reg) * DIV_W'(tooth_count_reg);
    end

    assign divisor = product_reg;

    // First position at or after ent_from whose phase has nonzero length.
    // Half period zero means tooth period one: only gap positions qualify.
    always_comb
    begin
        ent_from  = cmd.enter_first ? '0 : ((IDX_W+1)'(idx_reg) + (IDX_W+1)'(1));
        n_pos     = (signal_mode_reg != '0) ? (IDX_W+1)'(1) : {1'b0, tooth_count_reg};
        gap_en    = (signal_mode_reg == '0) && (missing_count_reg <= tooth_count_reg);
        gap_first = tooth_count_reg - missing_count_reg;
        ent_cand  = (ent_from >= {1'b0, gap_first}) ? ent_from : {1'b0, gap_first};
        ent_kind  = KIND_START;
        ent_idx   = '0;
        if ((ent_from < n_pos) && (period_reg != '0))
        begin
            if (half_reg != '0)
            begin
                ent_idx  = ent_from[IDX_W-1:0];
                ent_kind = (gap_en && (ent_from >= {1'b0, gap_first})) ? KIND_GAP : KIND_HIGH;
            end
            else if (gap_en && (ent_cand < n_pos))
            begin
                ent_idx  = ent_cand[IDX_W-1:0];
                ent_kind = KIND_GAP;
            end
        end
    end

    always_comb
    begin
        cnt_inc   = cnt_reg + 1'b1;
        phase_len = (kind_reg == KIND_GAP) ? period_reg : {1'b0, half_reg};

        period_next = period_reg;
        half_next   = half_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        kind_next   = kind_reg;

        if (cmd.period_load)
        begin
            period_next = quotient;
            half_next   = quotient[QUO_W-1:1];
        end

        if (cmd.enter_first)
        begin
            kind_next = ent_kind;
            idx_next  = ent_idx;
            cnt_next  = '0;
        end

        if (cmd.step && cmd.advance && (kind_reg != KIND_START))
        begin
            if (cnt_inc >= phase_len)
            begin
                cnt_next = '0;
                if ((kind_reg == KIND_HIGH) && (half_reg != '0))
                begin
                    kind_next = KIND_LOW;
                end
                else
                begin
                    kind_next = ent_kind;
                    idx_next  = ent_idx;
                end
            end
            else
            begin
                cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= '0;
            half_reg   <= '0;
            idx_reg    <= '0;
            cnt_reg    <= '0;
            kind_reg   <= KIND_START;
        end
        else
        begin
            period_reg <= period_next;
            half_reg   <= half_next;
            idx_reg    <= idx_next;
            cnt_reg    <= cnt_next;
            kind_reg   <= kind_next;
        end
    end

    // output word shows the phase before the tick advances it
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            pin_reg <= (kind_reg == KIND_HIGH);
            pos_reg <= idx_reg;
            gap_reg <= (kind_reg == KIND_GAP);
        end
    end

    assign pin_level      = pin_reg;
    assign tooth_position = pos_reg;
    assign in_gap         = gap_reg;

    assign status.at_start = (kind_reg == KIND_START);
    assign status.run_ok   = (speed_rpm_reg != '0) && (tooth_count_reg != '0);

    a_running_has_period: assert property (@(posedge clk) disable iff (!rst_n)
        kind_reg != KIND_START |-> period_reg != '0)
        else $error("phase active with zero tooth period");

    a_counter_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
        kind_reg != KIND_START |-> cnt_reg < phase_len)
        else $error("phase counter past phase length");

endmodule

[hdl/cwg_ctl.sv]
`timescale 1ns / 1ps
// Controller: input/output handshake and sequencing of the period computation.
// Depends on cwg_pkg; commands cwg_dp and cwg_div.
module cwg_ctl import cwg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic        tick,
    input  cwg_status_t status,
    input  logic        div_done,
    output cwg_cmd_t    cmd,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_START = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_ENTER = 6'b010000,
        ST_STEP  = 6'b100000
    } ctl_state_t;

    ctl_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       tick_reg;
    logic       accept;
    logic       out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.advance = tick_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (tick && status.at_start && status.run_ok)
                        state_next = ST_MUL;
                    else
                        state_next = ST_STEP;
                end
            end
            ST_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = ST_START;
            end
            ST_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    cmd.period_load = 1'b1;
                    state_next      = ST_ENTER;
                end
            end
            ST_ENTER:
            begin
                cmd.enter_first = 1'b1;
                state_next      = ST_STEP;
            end
            ST_STEP:
            begin
                if (out_free)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.step)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            tick_reg <= tick;
    end

    assign m_axis_tvalid = out_valid_reg;

    a_start_runs_divider: assert property (@(posedge clk) disable iff (!rst_n)
        accept && tick && status.at_start && status.run_ok |=> state_reg == ST_MUL)
        else $error("revolution start did not launch period computation");

    a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> out_valid_reg)
        else $error("emitted word not presented");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for crank_trigger_wheel_generator: streams tick words, predicts
// the pin/position/gap word for each, and checks every output word in order.
// Depends on cwg_pkg and the RTL of the block; nothing else.
module tb;
    import cwg_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1400;
    localparam int END_PAUSE    = 40;

    // any index past the last register must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(9);

    typedef struct packed {
        logic       gap;
        logic [7:0] pos;
        logic       pin;
    } crank_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    // copy of the block's registers and wheel state
    logic [15:0] rpm_r = 16'd0;
    logic [7:0]  mode_r = 8'd0;
    logic [7:0]  teeth_r = 8'd60;
    logic [7:0]  missing_r = 8'd2;
    logic [25:0] tooth_len = '0;
    logic [24:0] half_len = '0;
    logic [7:0]  pos_r = '0;
    logic [25:0] phase_cnt = '0;
    kind_t       kind_r = KIND_START;

    bit          pending_ticks[$];
    crank_word_t expected_words[$];
    crank_word_t exp_w;

    int          burst_left = 0;
    int          gap_left = 0;
    logic [31:0] rx_cycle = '0;
    int          hold_left = 0;
    int          cycle_count = 0;
    int          errors = 0;
    int          words_checked = 0;
    int          high_words = 0;
    int          gap_words = 0;
    int          rev_starts = 0;
    int          settings = 0;

    crank_trigger_wheel_generator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    // Find the first position at idx or later whose first phase has nonzero length.
    function void enter_position(int idx);
        bit gap_pos;
        while (idx < ((mode_r != 8'd0) ? 1 : int'(teeth_r)))
        begin
            gap_pos = (mode_r == 8'd0) && (missing_r <= teeth_r) &&
                      (idx >= int'(teeth_r) - int'(missing_r));
            pos_r = 8'(idx);
            phase_cnt = '0;
            if (gap_pos ? (tooth_len != 0) : (half_len != 0))
            begin
                kind_r = gap_pos ? KIND_GAP : KIND_HIGH;
                return;
            end
            idx++;
        end
        kind_r = KIND_START;
        pos_r = '0;
        phase_cnt = '0;
    endfunction

    function void predict_word(bit tick);
        crank_word_t w;
        logic [31:0] rot;
        if (tick && kind_r == KIND_START)
        begin
            pos_r = '0;
            phase_cnt = '0;
            if (rpm_r != 0 && teeth_r != 0)
            begin
                rot = 32'(US_PER_MINUTE) / 32'(rpm_r);
                tooth_len = 26'(rot / 32'(teeth_r));
                half_len = 25'(tooth_len / 2);
                rev_starts++;
                enter_position(0);
            end
        end
        w.pin = (kind_r == KIND_HIGH);
        w.pos = pos_r;
        w.gap = (kind_r == KIND_GAP);
        expected_words.push_back(w);
        if (tick && kind_r != KIND_START)
        begin
            phase_cnt = phase_cnt + 26'd1;
            if (phase_cnt >= ((kind_r == KIND_GAP) ? tooth_len : 26'(half_len)))
            begin
                if (kind_r == KIND_HIGH && half_len != 0)
                begin
                    kind_r = KIND_LOW;
                    phase_cnt = '0;
                end
                else
                    enter_position(int'(pos_r) + 1);
            end
        end
    endfunction

    // 8-bit registers get random upper data bits; the block must drop them
    function automatic logic [CFG_DATA_W-1:0] pad_byte(logic [7:0] v);
        return {8'($urandom), v};
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            REG_SPEED_RPM:     rpm_r = data;
            REG_SIGNAL_MODE:   mode_r = data[7:0];
            REG_TOOTH_COUNT:   teeth_r = data[7:0];
            REG_MISSING_COUNT: missing_r = data[7:0];
            default:           ;
        endcase
    endtask

    // queue ticks, then wait until every word has come back
    task automatic send_ticks(input int count, input int pct_one);
        for (int k = 0; k < count; k++)
            pending_ticks.push_back($urandom_range(0, 99) < pct_one);
        while (pending_ticks.size() != 0 || s_valid || expected_words.size() != 0)
            @(negedge clk);
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid <= 1'b0;
            s_tdata <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (s_valid && s_ready)
                predict_word(s_tdata[0]);
            if (!s_valid || s_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end
                else if (pending_ticks.size() != 0)
                begin
                    s_tdata <= S_TDATA_W'(pending_ticks.pop_front());
                    s_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 48);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern cycles through four styles, plus a long hold-off now and then
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_ready <= 1'b0;
            rx_cycle <= '0;
            hold_left <= 0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end
            else if (rx_cycle % 3000 == 1500)
            begin
                hold_left <= 300;
                m_ready <= 1'b0;
            end
            else
            begin
                case (rx_cycle[10:9])
                    2'd0: m_ready <= 1'b1;
                    2'd1: m_ready <= rx_cycle[0];
                    2'd2: m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= (rx_cycle[3:0] > 4'd4);
                endcase
            end
        end
    end

    // monitor: every output word against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            exp_w = '0;
        else if (m_valid && m_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("output word %h with no prediction pending", m_tdata);
                errors++;
            end
            else
            begin
                exp_w = expected_words.pop_front();
                words_checked++;
                if (m_tdata[0]) high_words++;
                if (m_tdata[9]) gap_words++;
                if (m_tdata[0] !== exp_w.pin)
                begin
                    $error("pin_level: expected %0d, got %0d", exp_w.pin, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[8:1] !== exp_w.pos)
                begin
                    $error("tooth_position: expected %0d, got %0d", exp_w.pos, m_tdata[8:1]);
                    errors++;
                end
                if (m_tdata[9] !== exp_w.gap)
                begin
                    $error("in_gap: expected %0d, got %0d", exp_w.gap, m_tdata[9]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int items_sent;
        int pick;
        int n;
        items_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // rpm is zero out of reset: output stays stopped
        send_ticks(1, 0);
        send_ticks(2, 100);

        // fastest pulse mode: tooth period 3, half 1
        write_reg(REG_SPEED_RPM, 16'hFFFF);
        write_reg(REG_SIGNAL_MODE, pad_byte(8'd1));
        write_reg(REG_TOOTH_COUNT, pad_byte(8'd255));
        send_ticks(4, 100);
        send_ticks(1, 0);
        send_ticks(1, 100);

        // wheel mode with zero teeth: stopped
        write_reg(REG_SIGNAL_MODE, pad_byte(8'd0));
        write_reg(REG_TOOTH_COUNT, pad_byte(8'd0));
        send_ticks(2, 100);

        // missing equals teeth: every position is a gap
        write_reg(REG_TOOTH_COUNT, pad_byte(8'd255));
        write_reg(REG_MISSING_COUNT, pad_byte(8'd255));
        send_ticks(4, 100);

        // shrink the wheel mid revolution, gap wider than the wheel
        write_reg(REG_TOOTH_COUNT, pad_byte(8'd5));
        write_reg(REG_MISSING_COUNT, pad_byte(8'd10));
        write_reg(REG_UNUSED, 16'hA5A5);
        send_ticks(6, 100);
        settings = 5;

        while (items_sent < RANDOM_ITEMS)
        begin
            settings++;
            pick = $urandom_range(0, 9);
            if (pick < 5)
            begin
                // wheel with short teeth so revolutions and gaps come around
                write_reg(REG_SIGNAL_MODE, pad_byte(8'd0));
                write_reg(REG_SPEED_RPM, 16'($urandom_range(30000, 65535)));
                write_reg(REG_TOOTH_COUNT, pad_byte(8'($urandom_range(100, 255))));
                write_reg(REG_MISSING_COUNT, pad_byte(8'($urandom_range(0, 4))));
            end
            else if (pick < 7)
            begin
                write_reg(REG_SIGNAL_MODE, pad_byte(8'($urandom_range(1, 255))));
                write_reg(REG_SPEED_RPM, 16'($urandom_range(20000, 65535)));
                write_reg(REG_TOOTH_COUNT, pad_byte(8'($urandom_range(20, 255))));
            end
            else if (pick == 7)
            begin
                // live counts: end the revolution early
                write_reg(REG_TOOTH_COUNT, pad_byte(8'($urandom_range(0, 20))));
                write_reg(REG_MISSING_COUNT, pad_byte(8'($urandom_range(0, 25))));
            end
            else
            begin
                write_reg(REG_SPEED_RPM, ($urandom_range(0, 2) == 0) ? 16'd0 : 16'hFFFF);
                case ($urandom_range(0, 2))
                    0: write_reg(REG_TOOTH_COUNT, pad_byte(8'd0));
                    1: write_reg(REG_TOOTH_COUNT, pad_byte(8'd1));
                    default: write_reg(REG_TOOTH_COUNT, pad_byte(8'd255));
                endcase
                write_reg(REG_MISSING_COUNT,
                          pad_byte(($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255));
                write_reg(REG_SIGNAL_MODE,
                          pad_byte(($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255));
            end
            n = $urandom_range(30, 150);
            send_ticks(n, 85);
            items_sent += n;
        end

        // run out the current revolution one tick at a time, then latch the slowest wheel
        write_reg(REG_SIGNAL_MODE, pad_byte(8'd1));
        while (kind_r != KIND_START)
            send_ticks(1, 100);
        write_reg(REG_SIGNAL_MODE, pad_byte(8'd0));
        write_reg(REG_SPEED_RPM, 16'd1);
        write_reg(REG_TOOTH_COUNT, pad_byte(8'd1));
        write_reg(REG_MISSING_COUNT, pad_byte(8'd0));
        send_ticks(4, 100);
        settings++;

        repeat (END_PAUSE) @(posedge clk);
        if (expected_words.size() != 0)
        begin
            $error("%0d predicted words never came out", expected_words.size());
            errors++;
        end
        $display("%0d output words checked over %0d register settings, %0d revolutions",
                 words_checked, settings, rev_starts);
        $display("%0d words with pin high, %0d words inside the gap", high_words, gap_words);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
